// ----- rtl/fwr_pkg.sv -----
package fwr_pkg;

    // payload words in one frame
    localparam int WORDS = 14;
    localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int ADDR_W = $clog2(2 * WORDS);

    localparam logic [15:0] CRC_SEED_RESET = 16'h00FF;

    // write and commit traffic from the parser into the frame buffer
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [15:0]      wr_data;
        logic             commit;
    } fwr_wr_t;

    // one byte of the reflected CCITT CRC, MCRF4XX style update
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] d;
        d = b ^ crc[7:0];
        d = d ^ {d[3:0], 4'b0000};
        return {d, crc[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b000};
    endfunction

endpackage

// ----- rtl/framed_word_receiver_crc16_top.sv -----
// channel  | handshake           | payload
// ---------+---------------------+----------------------------------------
// input    | in_valid / in_stall | rx_byte[7:0]
// output   | out_valid/out_stall | word_index[5:0], word_value[15:0], last
// config   | cfg_write           | cfg_data[15:0] (CRC seed)
//
// One byte is taken per cycle unless stalled; parser and CRC update are combinational.
// A good frame is released as WORDS words, one per cycle unless out_stall holds, from a
// two-bank buffer; the commit on the last CRC byte is registered, then out_valid is set.
// in_stall is high only while both banks hold frames not yet fully read out.
// Reset returns the parser to the header hunt and empties the buffer; no clearing pass.
module framed_word_receiver_crc16_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [5:0]         word_index,
    output logic signed [15:0] word_value,
    output logic               last,
    input  logic               cfg_write,
    input  logic [15:0]        cfg_data
);
    import fwr_pkg::*;

    fwr_wr_t wr;
    logic    full;
    logic    accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    fwr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .wr        (wr)
    );

    fwr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .full       (full),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .word_index (word_index),
        .word_value (word_value),
        .last       (last)
    );

endmodule

// ----- rtl/fwr_front.sv -----
module fwr_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      rx_byte,
    input  logic            cfg_write,
    input  logic [15:0]     cfg_data,
    output fwr_pkg::fwr_wr_t wr
);
    import fwr_pkg::*;

    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_STAR = 8'h2A;

    typedef enum logic [7:0] {
        HUNT1 = 8'b0000_0001,
        HUNT2 = 8'b0000_0010,
        HUNT3 = 8'b0000_0100,
        DESC  = 8'b0000_1000,
        LO    = 8'b0001_0000,
        HI    = 8'b0010_0000,
        CRCLO = 8'b0100_0000,
        CRCHI = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       lo_reg, lo_next;
    logic [7:0]       rxcrc_lo_reg, rxcrc_lo_next;
    logic [15:0]      seed_reg;
    logic [15:0]      crc_upd;

    assign crc_upd = crc_step(crc_reg, rx_byte);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        crc_next      = crc_reg;
        lo_next       = lo_reg;
        rxcrc_lo_next = rxcrc_lo_reg;
        wr.wr_en      = 1'b0;
        wr.wr_idx     = idx_reg;
        wr.wr_data    = {rx_byte, lo_reg};
        wr.commit     = 1'b0;
        if (accept)
        begin
            case (state_reg)
                HUNT1:
                begin
                    state_next = (rx_byte == CH_GT) ? HUNT2 : HUNT1;
                end
                HUNT2:
                begin
                    if (rx_byte == CH_STAR)
                        state_next = HUNT3;
                    else
                        state_next = (rx_byte == CH_GT) ? HUNT2 : HUNT1;
                end
                HUNT3:
                begin
                    if (rx_byte == CH_GT)
                    begin
                        state_next = DESC;
                        crc_next   = seed_reg;
                        idx_next   = '0;
                    end
                    else
                        state_next = HUNT1;
                end
                DESC:
                begin
                    state_next = LO;
                end
                LO:
                begin
                    crc_next   = crc_upd;
                    lo_next    = rx_byte;
                    state_next = HI;
                end
                HI:
                begin
                    crc_next = crc_upd;
                    wr.wr_en = 1'b1;
                    if (idx_reg == IDX_W'(WORDS - 1))
                    begin
                        idx_next   = '0;
                        state_next = CRCLO;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = LO;
                    end
                end
                CRCLO:
                begin
                    rxcrc_lo_next = rx_byte;
                    state_next    = CRCHI;
                end
                CRCHI:
                begin
                    // hand the frame over only on a good check, else drop it
                    wr.commit  = ({rx_byte, rxcrc_lo_reg} == crc_reg);
                    state_next = HUNT1;
                end
                default:
                begin
                    state_next = HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= HUNT1;
            idx_reg      <= '0;
            crc_reg      <= CRC_SEED_RESET;
            lo_reg       <= '0;
            rxcrc_lo_reg <= '0;
            seed_reg     <= CRC_SEED_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            crc_reg      <= crc_next;
            lo_reg       <= lo_next;
            rxcrc_lo_reg <= rxcrc_lo_next;
            if (cfg_write)
                seed_reg <= cfg_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        wr.commit |-> state_reg == CRCHI)
        else $error("commit outside the check byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr.wr_en |-> state_reg == HI)
        else $error("word write outside the high byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && state_reg == HI && idx_reg == IDX_W'(WORDS - 1)) |=> state_reg == CRCLO)
        else $error("payload did not end after the last word");

endmodule

// ----- rtl/fwr_back.sv -----
module fwr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  fwr_pkg::fwr_wr_t wr,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [5:0]       word_index,
    output logic signed [15:0] word_value,
    output logic             last
);
    import fwr_pkg::*;

    // two frame banks: the parser fills one while the other drains
    logic [15:0] mem [0:2*WORDS-1];

    logic [1:0]       full_cnt_reg, full_cnt_next;
    logic             wr_bank_reg, wr_bank_next;
    logic             rd_bank_reg, rd_bank_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [5:0]       word_index_reg;
    logic signed [15:0] word_value_reg;
    logic             last_reg;

    logic              load;
    logic              have;
    logic              take;
    logic              release_bank;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;

    assign waddr = ADDR_W'(wr.wr_idx) + (wr_bank_reg ? ADDR_W'(WORDS) : ADDR_W'(0));
    assign raddr = ADDR_W'(rd_idx_reg) + (rd_bank_reg ? ADDR_W'(WORDS) : ADDR_W'(0));

    assign load         = !out_valid_reg || !out_stall;
    assign have         = (full_cnt_reg != 2'd0);
    assign take         = load && have;
    assign release_bank = take && (rd_idx_reg == IDX_W'(WORDS - 1));

    always_comb
    begin
        out_valid_next = load ? have : out_valid_reg;
        rd_idx_next    = rd_idx_reg;
        if (take)
            rd_idx_next = release_bank ? '0 : rd_idx_reg + 1'b1;
        rd_bank_next  = rd_bank_reg ^ release_bank;
        wr_bank_next  = wr_bank_reg ^ wr.commit;
        full_cnt_next = full_cnt_reg + {1'b0, wr.commit} - {1'b0, release_bank};
    end

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
            mem[waddr] <= wr.wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_value_reg <= mem[raddr];
            word_index_reg <= 6'(rd_idx_reg);
            last_reg       <= (rd_idx_reg == IDX_W'(WORDS - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_cnt_reg  <= '0;
            wr_bank_reg   <= 1'b0;
            rd_bank_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            full_cnt_reg  <= full_cnt_next;
            wr_bank_reg   <= wr_bank_next;
            rd_bank_reg   <= rd_bank_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign full       = (full_cnt_reg == 2'd2);
    assign out_valid  = out_valid_reg;
    assign word_index = word_index_reg;
    assign word_value = word_value_reg;
    assign last       = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr.wr_en && !wr.commit)
        else $error("parser wrote while both banks were held");

    assert property (@(posedge clk) disable iff (!rst_n)
        full_cnt_reg != 2'd3)
        else $error("frame count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (full_cnt_reg == 2'd2) |-> (wr_bank_reg == rd_bank_reg))
        else $error("bank pointers out of step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> word_index_reg == 6'(WORDS - 1))
        else $error("last word flagged at wrong index");

endmodule
